>>> rtl/core/ggd_pkg.sv
// ggd_pkg: shared types, constants and helpers for the grid gradient block.
// Used by ggd_store, ggd_alu and grid_gradient_divergence.
package ggd_pkg;

	localparam int MAX_COLS = 64;
	localparam int MAX_ROWS = 64;
	localparam int COL_W    = $clog2(MAX_COLS);
	localparam int ROW_W    = $clog2(MAX_ROWS);
	localparam int ADDR_W   = ROW_W + COL_W;
	localparam int DIM_W    = 7;
	localparam int SAMPLE_W = 32;
	localparam int OUT_W    = 48;
	localparam int ACC_W    = 44;
	localparam int PROD_W   = 52;
	localparam int IDX_W    = 2;

	localparam logic [IDX_W-1:0] REG_COLS = 2'd0;
	localparam logic [IDX_W-1:0] REG_ROWS = 2'd1;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_READ  = 1'b1;

	typedef struct packed {
		logic                       action;
		logic [5:0]                 row;
		logic [5:0]                 col;
		logic signed [SAMPLE_W-1:0] sample;
	} cmd_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] grad_x;
		logic signed [OUT_W-1:0] grad_y;
		logic signed [OUT_W-1:0] divergence;
	} result_t;

	// two cells differenced by one gradient evaluation
	typedef struct packed {
		logic [ROW_W-1:0] a_r;
		logic [COL_W-1:0] a_c;
		logic [ROW_W-1:0] b_r;
		logic [COL_W-1:0] b_c;
		logic             half;
	} pair_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
			input logic [DIM_W-1:0] hi);
		logic [DIM_W-1:0] res;
		res = v;
		if (v < DIM_W'(3)) res = DIM_W'(3);
		else if (v > hi) res = hi;
		return res;
	endfunction

	// one-sided at the edges, central inside
	function automatic pair_t grad_pair(input logic axis_y, input logic [ROW_W-1:0] r,
			input logic [COL_W-1:0] c, input logic [DIM_W-1:0] n);
		pair_t            p;
		logic [COL_W-1:0] pos;
		logic [COL_W-1:0] pa;
		logic [COL_W-1:0] pb;
		pos = axis_y ? c : c;
		if (axis_y) pos = COL_W'(r);
		p.half = 1'b0;
		if (pos == '0) begin
			pa = COL_W'(1);
			pb = '0;
		end else if ({1'b0, pos} == n - DIM_W'(1)) begin
			pa = pos;
			pb = pos - COL_W'(1);
		end else begin
			pa = pos + COL_W'(1);
			pb = pos - COL_W'(1);
			p.half = 1'b1;
		end
		if (axis_y) begin
			p.a_r = ROW_W'(pa);
			p.b_r = ROW_W'(pb);
			p.a_c = c;
			p.b_c = c;
		end else begin
			p.a_r = r;
			p.b_r = r;
			p.a_c = pa;
			p.b_c = pb;
		end
		return p;
	endfunction

	function automatic logic signed [OUT_W-1:0] sat48(input logic signed [PROD_W-1:0] v);
		logic signed [OUT_W-1:0] res;
		res = v[OUT_W-1:0];
		if (v > $signed({{(PROD_W-OUT_W){1'b0}}, 1'b0, {(OUT_W-1){1'b1}}}))
			res = {1'b0, {(OUT_W-1){1'b1}}};
		else if (v < $signed({{(PROD_W-OUT_W){1'b1}}, 1'b1, {(OUT_W-1){1'b0}}}))
			res = {1'b1, {(OUT_W-1){1'b0}}};
		return res;
	endfunction

endpackage

>>> rtl/core/ggd_store.sv
// ggd_store: single-port sample memory, registered read.
// Depends on ggd_pkg.
module ggd_store import ggd_pkg::*; (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic                       rd_en,
	input  logic [ADDR_W-1:0]          addr,
	input  logic signed [SAMPLE_W-1:0] wr_data,
	output logic signed [SAMPLE_W-1:0] rd_data
);

	logic signed [SAMPLE_W-1:0] mem_q [MAX_ROWS*MAX_COLS];

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[addr] <= wr_data;
		if (rd_en) rd_data <= mem_q[addr];
	end

endmodule

>>> rtl/core/ggd_alu.sv
// ggd_alu: shared subtract-and-scale unit, product registered.
// Depends on ggd_pkg.
module ggd_alu import ggd_pkg::*; (
	input  logic                     clk,
	input  logic signed [ACC_W-1:0]  x,
	input  logic signed [ACC_W-1:0]  y,
	input  logic [DIM_W-1:0]         scale,
	output logic signed [PROD_W-1:0] prod_q
);

	logic signed [ACC_W:0]    diff;
	logic signed [PROD_W-1:0] diff_w;

	assign diff = {x[ACC_W-1], x} - {y[ACC_W-1], y};
	// widen before the multiply so the product keeps all its bits
	assign diff_w = PROD_W'(diff);

	always_ff @(posedge clk) begin
		prod_q <= diff_w * $signed({1'b0, scale});
	end

endmodule

>>> rtl/core/grid_gradient_divergence.sv
// grid_gradient_divergence: top level, sequencer around store and shared unit.
// Depends on ggd_pkg, ggd_store, ggd_alu.
//
// A write item leaves busy low and no result follows.
// A read item holds busy high; it reads the single-port sample store twice for
// each gradient term that the cell needs and skips the rest: an edge cell needs
// two terms, a corner four, an interior cell six, a cell outside the active
// grid none.
// done pulses one cycle with the result; the receiver cannot stall it.
// Reset clears control and config (64 x 64); the store is not cleared.
module grid_gradient_divergence import ggd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  cmd_t             cmd,
	output logic             done,
	output result_t          result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0] cfg_data
);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_RDA  = 7'b0000010,
		S_RDB  = 7'b0000100,
		S_MUL  = 7'b0001000,
		S_ACC  = 7'b0010000,
		S_DMUL = 7'b0100000,
		S_DACC = 7'b1000000
	} state_t;

	// accumulator targets
	localparam logic [1:0] T_X = 2'd0;
	localparam logic [1:0] T_Y = 2'd1;
	localparam logic [1:0] T_D = 2'd2;

	state_t                     state_q;
	logic [DIM_W-1:0]           cols_q, rows_q;
	logic [DIM_W-1:0]           nc_q, nr_q;
	logic [ROW_W-1:0]           r_q, vr_q;
	logic [COL_W-1:0]           c_q, hc_q;
	logic                       corner_q, interior_q, inside_q;
	logic [2:0]                 step_q;
	logic signed [ACC_W-1:0]    acc_x_q, acc_y_q, acc_d_q;
	logic signed [SAMPLE_W-1:0] fa_q;
	logic                       done_q;
	result_t                    result_q;

	// effective dims of the incoming item
	logic [DIM_W-1:0] nc, nr;
	logic             in_inside, row_edge, col_edge;

	assign nc = clamp_dim(cols_q, DIM_W'(MAX_COLS));
	assign nr = clamp_dim(rows_q, DIM_W'(MAX_ROWS));
	assign in_inside = ({1'b0, cmd.row} < nr) && ({1'b0, cmd.col} < nc);
	assign row_edge  = (cmd.row == '0) || ({1'b0, cmd.row} == nr - DIM_W'(1));
	assign col_edge  = (cmd.col == '0) || ({1'b0, cmd.col} == nc - DIM_W'(1));

	logic accept;
	assign accept = start && (state_q == S_IDLE);

	// step decode: which gradient term this step evaluates
	logic [ROW_W-1:0] sr;
	logic [COL_W-1:0] sc;
	logic             axis_y, neg, step_en;
	logic [1:0]       target;

	always_comb begin
		sr      = r_q;
		sc      = c_q;
		axis_y  = 1'b0;
		neg     = 1'b0;
		step_en = 1'b0;
		target  = T_X;
		case (step_q)
			3'd0: begin
				sc      = corner_q ? hc_q : c_q;
				step_en = inside_q;
			end
			3'd1: begin
				sr      = vr_q;
				step_en = corner_q;
			end
			3'd2: begin
				sc      = corner_q ? hc_q : c_q;
				axis_y  = 1'b1;
				target  = T_Y;
				step_en = inside_q;
			end
			3'd3: begin
				sr      = vr_q;
				axis_y  = 1'b1;
				target  = T_Y;
				step_en = corner_q;
			end
			3'd4: begin
				sc      = c_q + COL_W'(1);
				target  = T_D;
				step_en = interior_q;
			end
			3'd5: begin
				sc      = c_q - COL_W'(1);
				neg     = 1'b1;
				target  = T_D;
				step_en = interior_q;
			end
			3'd6: begin
				sr      = r_q + ROW_W'(1);
				axis_y  = 1'b1;
				target  = T_D;
				step_en = interior_q;
			end
			3'd7: begin
				sr      = r_q - ROW_W'(1);
				axis_y  = 1'b1;
				neg     = 1'b1;
				target  = T_D;
				step_en = interior_q;
			end
			default: begin
				step_en = 1'b0;
			end
		endcase
	end

	pair_t            pair;
	logic [DIM_W-1:0] scale;
	assign scale = axis_y ? nr_q : nc_q;
	assign pair  = grad_pair(axis_y, sr, sc, scale);

	// store port
	logic                       st_wr, st_rd;
	logic [ADDR_W-1:0]          st_addr;
	logic signed [SAMPLE_W-1:0] rd_data;

	always_comb begin
		st_wr   = accept && (cmd.action == ACT_WRITE);
		st_rd   = 1'b0;
		st_addr = {cmd.row, cmd.col};
		if (state_q == S_RDA) begin
			st_rd   = step_en;
			st_addr = {pair.a_r, pair.a_c};
		end else if (state_q == S_RDB) begin
			st_rd   = 1'b1;
			st_addr = {pair.b_r, pair.b_c};
		end
	end

	ggd_store u_store (
		.clk     (clk),
		.wr_en   (st_wr),
		.rd_en   (st_rd),
		.addr    (st_addr),
		.wr_data (cmd.sample),
		.rd_data (rd_data)
	);

	// shared unit: (x - y) * scale
	logic signed [ACC_W-1:0]  alu_x, alu_y;
	logic [DIM_W-1:0]         alu_s;
	logic signed [PROD_W-1:0] prod;

	always_comb begin
		if (state_q == S_DMUL) begin
			alu_x = acc_d_q;
			alu_y = '0;
			alu_s = nr_q;
		end else begin
			alu_x = ACC_W'(fa_q);
			alu_y = ACC_W'(rd_data);
			alu_s = scale;
		end
	end

	ggd_alu u_alu (
		.clk    (clk),
		.x      (alu_x),
		.y      (alu_y),
		.scale  (alu_s),
		.prod_q (prod)
	);

	logic signed [PROD_W-1:0] half_prod;
	logic signed [ACC_W-1:0]  term;
	assign half_prod = prod >>> 1;
	assign term = pair.half ? half_prod[ACC_W-1:0] : prod[ACC_W-1:0];

	logic signed [PROD_W-1:0] gx_full, gy_full;
	assign gx_full = corner_q ? PROD_W'(acc_x_q >>> 1) : PROD_W'(acc_x_q);
	assign gy_full = corner_q ? PROD_W'(acc_y_q >>> 1) : PROD_W'(acc_y_q);

	// config registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= DIM_W'(MAX_COLS);
			rows_q <= DIM_W'(MAX_ROWS);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_COLS: cols_q <= cfg_data;
				REG_ROWS: rows_q <= cfg_data;
				default:  ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept && cmd.action == ACT_READ) begin
						step_q  <= '0;
						state_q <= S_RDA;
					end
				end
				S_RDA: begin
					if (step_en) state_q <= S_RDB;
					else if (step_q == 3'd7) state_q <= S_DMUL;
					else step_q <= step_q + 3'd1;
				end
				S_RDB: state_q <= S_MUL;
				S_MUL: state_q <= S_ACC;
				S_ACC: begin
					if (step_q == 3'd7) begin
						state_q <= S_DMUL;
					end else begin
						step_q  <= step_q + 3'd1;
						state_q <= S_RDA;
					end
				end
				S_DMUL: state_q <= S_DACC;
				S_DACC: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept && cmd.action == ACT_READ) begin
			r_q        <= cmd.row;
			c_q        <= cmd.col;
			nc_q       <= nc;
			nr_q       <= nr;
			hc_q       <= (cmd.col == '0) ? COL_W'(1) : COL_W'(nc - DIM_W'(2));
			vr_q       <= (cmd.row == '0) ? ROW_W'(1) : ROW_W'(nr - DIM_W'(2));
			inside_q   <= in_inside;
			corner_q   <= in_inside && row_edge && col_edge;
			interior_q <= in_inside && !row_edge && !col_edge;
			acc_x_q    <= '0;
			acc_y_q    <= '0;
			acc_d_q    <= '0;
		end
		if (state_q == S_RDB) fa_q <= rd_data;
		if (state_q == S_ACC) begin
			case (target)
				T_X:     acc_x_q <= acc_x_q + term;
				T_Y:     acc_y_q <= acc_y_q + term;
				T_D:     acc_d_q <= neg ? acc_d_q - term : acc_d_q + term;
				default: ;
			endcase
		end
		if (state_q == S_DACC) begin
			result_q.grad_x     <= sat48(gx_full);
			result_q.grad_y     <= sat48(gy_full);
			result_q.divergence <= interior_q ? sat48(half_prod) : '0;
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

	a_done_after_dacc: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == S_DACC))
		else $error("result strobe without finishing step");

	a_write_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd.action == ACT_WRITE) |=> (state_q == S_IDLE))
		else $error("write item left the sequencer busy");

	a_read_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd.action == ACT_READ) |=> (busy && step_q == 3'd0))
		else $error("read item did not start the sequence");

	a_no_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && state_q != S_IDLE) |-> !done_q || $past(state_q == S_DACC))
		else $error("strobe while sequence running");

endmodule

>>> test/testbench.sv
// testbench: self-checking bench for grid_gradient_divergence.
// Depends on ggd_pkg and the RTL; has its own gradient/divergence predictor.
`timescale 1ns / 1ps

module testbench;
	import ggd_pkg::*;

	// what one entry of the pending list asks the driver to do
	typedef enum int {K_CMD, K_CFG, K_MODE, K_PAUSE} op_kind_t;

	typedef struct {
		op_kind_t         kind;
		cmd_t             c;
		logic [IDX_W-1:0] idx;
		logic [DIM_W-1:0] data;
		int               pct;
	} pending_op_t;

	localparam longint SAT_HI = 64'sd140737488355327;
	localparam longint SAT_LO = -64'sd140737488355328;

	// indexes with no register behind them
	localparam logic [IDX_W-1:0] REG_UNUSED2 = 2'd2;
	localparam logic [IDX_W-1:0] REG_UNUSED3 = 2'd3;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic             busy;
	cmd_t             cmd = '0;
	logic             done;
	result_t          result;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [DIM_W-1:0] cfg_data = '0;

	grid_gradient_divergence dut (
		.clk, .arst_n, .start, .busy, .cmd, .done, .result,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	always #6 clk = ~clk;

	// predictor state: its own copy of the store and the two dimension registers
	logic signed [SAMPLE_W-1:0] grid_mem [MAX_ROWS*MAX_COLS];
	logic [DIM_W-1:0]           cols_reg = 7'd64;
	logic [DIM_W-1:0]           rows_reg = 7'd64;

	pending_op_t pending_ops[$];
	result_t     expected_grads[$];
	int          fail_count = 0;
	int          idle_pct = 0;
	int          quiet_cycles = 0;
	bit          cmd_taken = 1'b0;
	bit          cfg_taken = 1'b0;

	function automatic int eff_dim(logic [DIM_W-1:0] v, int hi);
		if (v < 3) return 3;
		if (v > hi) return hi;
		return int'(v);
	endfunction

	function automatic longint smp(int r, int c);
		return longint'(grid_mem[r*MAX_COLS + c]);
	endfunction

	// x gradient at a non-corner cell: one-sided at the edges, halved central inside
	function automatic longint grad_x_of(int r, int c, int nc);
		if (c == 0) return nc * (smp(r, 1) - smp(r, 0));
		if (c == nc-1) return nc * (smp(r, c) - smp(r, c-1));
		return (nc * (smp(r, c+1) - smp(r, c-1))) >>> 1;
	endfunction

	function automatic longint grad_y_of(int r, int c, int nr);
		if (r == 0) return nr * (smp(1, c) - smp(0, c));
		if (r == nr-1) return nr * (smp(r, c) - smp(r-1, c));
		return (nr * (smp(r+1, c) - smp(r-1, c))) >>> 1;
	endfunction

	function automatic logic signed [OUT_W-1:0] clip48(longint v);
		if (v > SAT_HI) return SAT_HI[OUT_W-1:0];
		if (v < SAT_LO) return SAT_LO[OUT_W-1:0];
		return v[OUT_W-1:0];
	endfunction

	function automatic result_t grad_div_of(cmd_t k);
		result_t res;
		int      nc, nr, r, c, hc, vr;
		bit      re, ce;
		longint  gx, gy, dv;
		nc = eff_dim(cols_reg, MAX_COLS);
		nr = eff_dim(rows_reg, MAX_ROWS);
		r = int'(k.row);
		c = int'(k.col);
		gx = 0;
		gy = 0;
		dv = 0;
		if (r < nr && c < nc) begin
			re = (r == 0 || r == nr-1);
			ce = (c == 0 || c == nc-1);
			if (re && ce) begin
				// corner: mean of the horizontal and vertical neighbor gradients
				hc = (c == 0) ? 1 : nc-2;
				vr = (r == 0) ? 1 : nr-2;
				gx = (grad_x_of(r, hc, nc) + grad_x_of(vr, c, nc)) >>> 1;
				gy = (grad_y_of(r, hc, nr) + grad_y_of(vr, c, nr)) >>> 1;
			end else begin
				gx = grad_x_of(r, c, nc);
				gy = grad_y_of(r, c, nr);
			end
			if (!re && !ce)
				dv = (nr * (grad_x_of(r, c+1, nc) - grad_x_of(r, c-1, nc)
					+ grad_y_of(r+1, c, nr) - grad_y_of(r-1, c, nr))) >>> 1;
		end
		res.grad_x = clip48(gx);
		res.grad_y = clip48(gy);
		res.divergence = clip48(dv);
		return res;
	endfunction

	// monitor: everything sampled at the rising edge
	always @(posedge clk) begin
		result_t want;
		cmd_taken = arst_n && start && !busy;
		cfg_taken = arst_n && cfg_valid && cfg_ready;
		if (cfg_taken) begin
			if (cfg_index == REG_COLS) cols_reg <= cfg_data;
			else if (cfg_index == REG_ROWS) rows_reg <= cfg_data;
		end
		if (done) begin
			if (expected_grads.size() == 0) begin
				$error("result with nothing expected");
				fail_count++;
			end else begin
				want = expected_grads.pop_front();
				if (result.grad_x !== want.grad_x) begin
					$error("grad_x exp %0d got %0d", want.grad_x, result.grad_x);
					fail_count++;
				end
				if (result.grad_y !== want.grad_y) begin
					$error("grad_y exp %0d got %0d", want.grad_y, result.grad_y);
					fail_count++;
				end
				if (result.divergence !== want.divergence) begin
					$error("divergence exp %0d got %0d", want.divergence,
						result.divergence);
					fail_count++;
				end
			end
		end
		if (cmd_taken) begin
			if (cmd.action == ACT_WRITE)
				grid_mem[{cmd.row, cmd.col}] = cmd.sample;
			else
				expected_grads.push_back(grad_div_of(cmd));
		end
	end

	// driver: inputs change on the falling edge, one assignment per signal
	always @(negedge clk) begin
		logic        nstart;
		logic        ncfg;
		pending_op_t op;
		nstart = start;
		ncfg = cfg_valid;
		if (start && cmd_taken) begin
			void'(pending_ops.pop_front());
			nstart = 1'b0;
		end
		if (cfg_valid && cfg_taken) begin
			void'(pending_ops.pop_front());
			ncfg = 1'b0;
		end
		// a write can leave no result, so count settled cycles before a register write
		if (expected_grads.size() == 0 && !busy && !start && !cfg_valid)
			quiet_cycles++;
		else
			quiet_cycles = 0;
		if (arst_n && !nstart && !ncfg && pending_ops.size() > 0) begin
			op = pending_ops[0];
			case (op.kind)
				K_MODE: begin
					idle_pct = op.pct;
					void'(pending_ops.pop_front());
				end
				K_PAUSE: begin
					if (expected_grads.size() == 0 && !busy)
						void'(pending_ops.pop_front());
				end
				K_CFG: begin
					if (quiet_cycles >= 48) begin
						ncfg = 1'b1;
						cfg_index <= op.idx;
						cfg_data <= op.data;
					end
				end
				default: begin
					if ($urandom_range(99) >= idle_pct) begin
						nstart = 1'b1;
						cmd <= op.c;
					end
				end
			endcase
		end
		start <= nstart;
		cfg_valid <= ncfg;
	end

	// ---------------- stimulus ----------------
	int gen_nc = 64;
	int gen_nr = 64;
	// cells already covered by a queued write
	bit gen_written [MAX_ROWS*MAX_COLS];

	// a read may only touch written cells; its reach is two cells each way
	function automatic bit read_ok(int r, int c);
		if (r >= gen_nr || c >= gen_nc) return 1'b1;
		for (int rr = r-2; rr <= r+2; rr++)
			for (int cc = c-2; cc <= c+2; cc++)
				if (rr >= 0 && rr < gen_nr && cc >= 0 && cc < gen_nc
						&& !gen_written[rr*MAX_COLS + cc])
					return 1'b0;
		return 1'b1;
	endfunction

	task automatic push_cmd(logic act, int r, int c, logic [31:0] v);
		pending_op_t op;
		op = '{K_CMD, '0, '0, '0, 0};
		op.c.action = act;
		op.c.row = r[5:0];
		op.c.col = c[5:0];
		op.c.sample = v;
		pending_ops.push_back(op);
		if (act == ACT_WRITE) gen_written[{r[5:0], c[5:0]}] = 1'b1;
	endtask

	task automatic push_cfg(logic [IDX_W-1:0] i, logic [DIM_W-1:0] d);
		pending_ops.push_back('{K_CFG, '0, i, d, 0});
		if (i == REG_COLS) gen_nc = eff_dim(d, MAX_COLS);
		if (i == REG_ROWS) gen_nr = eff_dim(d, MAX_ROWS);
	endtask

	task automatic push_mode(int p);
		pending_ops.push_back('{K_MODE, '0, '0, '0, p});
	endtask

	function automatic logic [31:0] pick_sample();
		case ($urandom_range(5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom_range(131072) - 65536;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		logic [6:0] dims [8][2];
		int         modes [4];
		int         r, c, n;
		foreach (grid_mem[i]) grid_mem[i] = '0;
		foreach (gen_written[i]) gen_written[i] = 1'b0;
		dims = '{'{7'd3, 7'd3}, '{7'd2, 7'd0}, '{7'd127, 7'd64}, '{7'd64, 7'd3},
			'{7'd5, 7'd9}, '{7'd4, 7'd70}, '{7'd1, 7'd6}, '{7'd8, 7'd127}};
		modes = '{0, 72, 0, 30};

		// fill the corner blocks and a patch in the middle so the directed reads
		// are defined; a checkerboard of the sample extremes drives big outputs
		for (int i = 0; i < MAX_ROWS*MAX_COLS; i++) begin
			r = i / MAX_COLS;
			c = i % MAX_COLS;
			if ((r < 4 || r > 59) && (c < 4 || c > 59))
				push_cmd(ACT_WRITE, r, c, ((r + c) % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF);
			else if (((r < 6 || r > 57) && (c < 6 || c > 57))
					|| (r >= 28 && r <= 32 && c >= 29 && c <= 33))
				push_cmd(ACT_WRITE, r, c, $urandom);
		end

		// directed reads at the reset size: corners, edges, interior
		push_cmd(ACT_READ, 0, 0, 32'hFFFF_FFFF);
		push_cmd(ACT_READ, 0, 63, 0);
		push_cmd(ACT_READ, 63, 0, 0);
		push_cmd(ACT_READ, 63, 63, 0);
		push_cmd(ACT_READ, 0, 2, 0);
		push_cmd(ACT_READ, 62, 63, 0);
		push_cmd(ACT_READ, 1, 1, 0);
		push_cmd(ACT_READ, 2, 62, 0);
		push_cmd(ACT_READ, 62, 62, 0);
		push_cmd(ACT_READ, 30, 31, 0);
		// smallest grid, then reads outside it and writes to the unused indexes
		push_cfg(REG_COLS, 7'd3);
		push_cfg(REG_ROWS, 7'd3);
		push_cmd(ACT_READ, 1, 1, 0);
		push_cmd(ACT_READ, 2, 2, 0);
		push_cmd(ACT_READ, 0, 1, 0);
		push_cmd(ACT_READ, 3, 0, 0);
		push_cmd(ACT_READ, 63, 63, 0);
		push_cfg(REG_UNUSED2, 7'd127);
		push_cfg(REG_UNUSED3, 7'd0);
		push_cmd(ACT_READ, 1, 1, 0);

		// random phases over several sizes and sender idling levels;
		// a read that would touch an unwritten cell becomes a write there
		for (int p = 0; p < 8; p++) begin
			push_cfg(REG_COLS, (p < 8) ? dims[p][0] : 7'd0);
			push_cfg(REG_ROWS, dims[p][1]);
			push_mode(modes[p % 4]);
			n = 0;
			while (n < 170) begin
				if (n == 85 && p % 2 == 1)
					pending_ops.push_back('{K_PAUSE, '0, '0, '0, 0});
				if ($urandom_range(99) < 45) begin
					if ($urandom_range(99) < 85) begin
						r = $urandom_range(gen_nr-1);
						c = $urandom_range(gen_nc-1);
					end else begin
						r = $urandom_range(63);
						c = $urandom_range(63);
					end
					if (read_ok(r, c))
						push_cmd(ACT_READ, r, c, $urandom);
					else
						push_cmd(ACT_WRITE, r, c, pick_sample());
				end else if ($urandom_range(99) < 80) begin
					push_cmd(ACT_WRITE, $urandom_range(gen_nr-1), $urandom_range(gen_nc-1),
						pick_sample());
				end else begin
					push_cmd(ACT_WRITE, $urandom_range(63), $urandom_range(63), pick_sample());
				end
				n++;
			end
		end
		// back to the reset size
		push_cfg(REG_COLS, 7'd64);
		push_cfg(REG_ROWS, 7'd64);
		for (int i = 0; i < 20; i++) begin
			do begin
				r = $urandom_range(63);
				c = $urandom_range(63);
			end while (!read_ok(r, c));
			push_cmd(ACT_READ, r, c, 0);
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (pending_ops.size() == 0);
		@(posedge clk);
		while (expected_grads.size() != 0 || start || cfg_valid || busy)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// watchdog
	initial begin
		#20ms;
		$display("== FAIL ==");
		$finish;
	end

endmodule

>>> grid_gradient_divergence.f
rtl/core/ggd_pkg.sv
rtl/core/ggd_store.sv
rtl/core/ggd_alu.sv
rtl/core/grid_gradient_divergence.sv
test/testbench.sv
